// File: sv/mthp_pkg.sv
package mthp_pkg;

   localparam int MODE_W = 4;

   localparam logic [MODE_W-1:0] MODE_LEAD  = 4'd0;
   localparam logic [MODE_W-1:0] MODE_TYPE  = 4'd1;
   localparam logic [MODE_W-1:0] MODE_SLASH = 4'd2;
   localparam logic [MODE_W-1:0] MODE_GAP   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_SEMI  = 4'd4;
   localparam logic [MODE_W-1:0] MODE_KEY   = 4'd5;
   localparam logic [MODE_W-1:0] MODE_EQ    = 4'd6;
   localparam logic [MODE_W-1:0] MODE_VAL   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_QUOTE = 4'd8;
   localparam logic [MODE_W-1:0] MODE_ESC   = 4'd9;

   localparam logic [1:0] PART_TYPE = 2'd0;
   localparam logic [1:0] PART_KEY  = 2'd1;
   localparam logic [1:0] PART_VAL  = 2'd2;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] out_char;
      logic [1:0] part;
      logic       field_open;
      logic       done_res;
      logic       accepted;
   } result_type;

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return c >= 8'h41 && c <= 8'h5A;
   endfunction

   function automatic logic is_tchar(input logic [7:0] c);
      return (c >= 8'h5E && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h23 && c <= 8'h27) || is_upper(c) ||
             c == 8'h21 || c == 8'h2A || c == 8'h2B || c == 8'h2D ||
             c == 8'h2E || c == 8'h7C || c == 8'h7E;
   endfunction

   function automatic logic is_qdtext(input logic [7:0] c);
      return c == CH_TAB || c == CH_SPACE || c == 8'h21 ||
             (c >= 8'h23 && c <= 8'h5B) || (c >= 8'h5D && c <= 8'h7E) || c[7];
   endfunction

   function automatic logic is_escapable(input logic [7:0] c);
      return c == CH_TAB || (c >= 8'h20 && c <= 8'h7E) || c[7];
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return is_upper(c) ? (c | 8'h20) : c;
   endfunction

endpackage

// File: sv/mthp_if.sv
interface mthp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, in_byte, is_last, input ready);
   modport sink (input valid, in_byte, is_last, output ready);
endinterface

interface mthp_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] out_char;
   logic [1:0] part;
   logic       field_open;
   logic       done_res;
   logic       accepted;

   modport source (output valid, char_valid, out_char, part, field_open, done_res,
                   accepted, input ready);
   modport sink (input valid, char_valid, out_char, part, field_open, done_res,
                 accepted, output ready);
endinterface

// File: sv/media_type_header_parser.sv
// Media type header parser.
// req_bus carries one header byte per transfer (in_byte) with is_last on the
// final byte of a header value. rsp_bus returns exactly one result per byte:
// the content character (lowercased in tokens, unescaped in quoted strings),
// the part it belongs to, a field_open pulse at each key and value, and on
// the last byte done_res with the accepted verdict. Errors are sticky until
// the last byte of the value; the next byte then starts a fresh value.
// A byte is captured in an input register, parsed combinationally and
// written to the result register, which drives rsp_bus.valid. One byte
// per cycle sustained unless the receiver stalls; the only loop is the
// 4-bit parse mode and failed flag, updated as a byte moves into the
// result register. When the receiver stalls, the result register holds
// and the input register fills; req_bus.ready drops only while both are
// occupied and the receiver stalls.
// Reset (synchronous) empties both registers and returns the parser to the
// leading blank skip state.
module media_type_header_parser
   import mthp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mthp_req_if.sink   req_bus,
   mthp_rsp_if.source rsp_bus
);

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;
   logic [MODE_W-1:0] mode_ff;
   logic              failed_ff;

   logic [MODE_W-1:0] mode_in;
   logic              failed_in;
   result_type        rsp_in;
   logic              advance;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;

   mthp_step u_step (
      .mode        (mode_ff),
      .failed      (failed_ff),
      .in_byte     (in_byte_ff),
      .is_last     (in_last_ff),
      .mode_next   (mode_in),
      .failed_next (failed_in),
      .result      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_LEAD;
         failed_ff    <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            mode_ff   <= mode_in;
            failed_ff <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.in_byte;
         in_last_ff <= req_bus.is_last;
      end
      if (advance && in_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.char_valid = rsp_ff.char_valid;
   assign rsp_bus.out_char   = rsp_ff.out_char;
   assign rsp_bus.part       = rsp_ff.part;
   assign rsp_bus.field_open = rsp_ff.field_open;
   assign rsp_bus.done_res   = rsp_ff.done_res;
   assign rsp_bus.accepted   = rsp_ff.accepted;

   a_reset_state: assert property (@(posedge clock)
      reset |=> (mode_ff == MODE_LEAD && !failed_ff && !in_valid_ff && !rsp_valid_ff))
      else $error("parser not in start state after reset");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && in_last_ff) |=> (mode_ff == MODE_LEAD && !failed_ff))
      else $error("last byte did not restart the parser");

   a_accept_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.accepted) |-> rsp_ff.done_res)
      else $error("accepted without done");

   a_no_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.char_valid) |-> (rsp_ff.out_char == 8'h00))
      else $error("out_char set without char_valid");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while both stages full and stalled");

endmodule

// File: sv/mthp_step.sv
module mthp_step
   import mthp_pkg::*;
(
   input  logic [MODE_W-1:0] mode,
   input  logic              failed,
   input  logic [7:0]        in_byte,
   input  logic              is_last,
   output logic [MODE_W-1:0] mode_next,
   output logic              failed_next,
   output result_type        result
);

   logic [MODE_W-1:0] m;
   logic              f;
   logic              cv;
   logic [7:0]        ch;
   logic [1:0]        pt;
   logic              fo;
   logic              type_byte;
   logic              sep_byte;

   always_comb begin
      m = mode;
      f = failed;
      cv = 1'b0;
      ch = 8'h00;
      pt = PART_TYPE;
      fo = 1'b0;
      type_byte = 1'b0;
      sep_byte = 1'b0;

      if (!failed) begin
         unique case (mode) inside
            MODE_LEAD: begin
               type_byte = !is_blank(in_byte);
            end
            MODE_TYPE, MODE_SLASH: begin
               type_byte = 1'b1;
            end
            MODE_GAP: begin
               sep_byte = 1'b1;
            end
            MODE_SEMI: begin
               if (is_tchar(in_byte)) begin
                  cv = 1'b1;
                  ch = to_lower(in_byte);
                  pt = PART_KEY;
                  fo = 1'b1;
                  m = MODE_KEY;
               end else if (in_byte == CH_EQUAL) begin
                  pt = PART_KEY;
                  fo = 1'b1;
                  m = MODE_EQ;
               end else if (!is_blank(in_byte)) begin
                  f = 1'b1;
               end
            end
            MODE_KEY: begin
               if (is_tchar(in_byte)) begin
                  cv = 1'b1;
                  ch = to_lower(in_byte);
                  pt = PART_KEY;
               end else if (in_byte == CH_EQUAL) begin
                  m = MODE_EQ;
               end else begin
                  f = 1'b1;
               end
            end
            MODE_EQ: begin
               pt = PART_VAL;
               fo = 1'b1;
               if (in_byte == CH_DQUOTE) begin
                  m = MODE_QUOTE;
               end else if (is_tchar(in_byte)) begin
                  cv = 1'b1;
                  ch = to_lower(in_byte);
                  m = MODE_VAL;
               end else begin
                  sep_byte = 1'b1;
               end
            end
            MODE_VAL: begin
               if (is_tchar(in_byte)) begin
                  cv = 1'b1;
                  ch = to_lower(in_byte);
                  pt = PART_VAL;
               end else begin
                  sep_byte = 1'b1;
               end
            end
            MODE_QUOTE: begin
               if (in_byte == CH_DQUOTE) begin
                  m = MODE_GAP;
               end else if (in_byte == CH_BSLASH) begin
                  m = MODE_ESC;
               end else if (is_qdtext(in_byte)) begin
                  cv = 1'b1;
                  ch = in_byte;
                  pt = PART_VAL;
               end else begin
                  f = 1'b1;
               end
            end
            MODE_ESC: begin
               if (is_escapable(in_byte)) begin
                  cv = 1'b1;
                  ch = in_byte;
                  pt = PART_VAL;
                  m = MODE_QUOTE;
               end else begin
                  f = 1'b1;
               end
            end
            default: begin
               f = 1'b1;
            end
         endcase

         if (type_byte) begin
            if (is_tchar(in_byte)) begin
               cv = 1'b1;
               ch = to_lower(in_byte);
               m = MODE_TYPE;
            end else if (in_byte == CH_SLASH) begin
               cv = 1'b1;
               ch = in_byte;
               m = MODE_SLASH;
            end else begin
               sep_byte = 1'b1;
            end
         end

         if (sep_byte) begin
            if (is_blank(in_byte)) begin
               m = MODE_GAP;
            end else if (in_byte == CH_SEMI) begin
               m = MODE_SEMI;
            end else begin
               f = 1'b1;
            end
         end
      end

      if (f) begin
         cv = 1'b0;
         ch = 8'h00;
         pt = PART_TYPE;
         fo = 1'b0;
      end

      result.char_valid = cv;
      result.out_char   = ch;
      result.part       = pt;
      result.field_open = fo;
      result.done_res   = is_last;
      result.accepted   = is_last && !f &&
                          (m == MODE_TYPE || m == MODE_GAP || m == MODE_VAL);

      mode_next   = is_last ? MODE_LEAD : m;
      failed_next = is_last ? 1'b0 : f;
   end

endmodule
